>>> hw/rtl/dea_pkg.sv
// Shared types, constants and helper functions of the double-ended arena allocator.
package dea_pkg;

  // Pointer arithmetic width and region granule (a power of two).
  localparam int ADDR_BITS   = 32;
  localparam int REGION_LOG2 = 8;

  // Field widths of the request and result channels.
  localparam int FUNC_W   = 3;
  localparam int SIZE_W   = 32;
  localparam int ALIGN_W  = 4;
  localparam int MARK_W   = 32;
  localparam int OFFSET_W = 32;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 32;

  // Internal compare width: wide enough for a rounded-up pointer plus a size.
  localparam int EXT_W = ((ADDR_BITS > CFG_W) ? ADDR_BITS : CFG_W) + 2;

  typedef logic [ADDR_BITS-1:0] ptr_t;
  typedef logic [EXT_W-1:0]     ext_t;

  localparam ext_t ADDR_MAX_E  = (ext_t'(1) << ADDR_BITS) - ext_t'(1);
  localparam ext_t REGION_MASK = (ext_t'(1) << REGION_LOG2) - ext_t'(1);

  localparam logic [CFG_W-1:0] ARENA_RESET = 32'hC000_0000;

  // Request operation codes.
  localparam logic [FUNC_W-1:0] FN_PERM_ALLOC = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SCR_ALLOC  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REWIND     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SCR_RESET  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ_MARK  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR_ALL  = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PERM_OOM   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PERM_CROSS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SCR_OOM    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALIGN_HIT  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_CK     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_PAST_LIVE  = 3'd6;

  // Pointer updates produced by one request.
  typedef struct packed {
    logic perm_we;
    ptr_t perm_nxt;
    logic scr_we;
    ptr_t scr_nxt;
  } dea_upd_t;

  // Arena size, saturated to the largest address.
  function automatic ext_t arena_size(input logic [CFG_W-1:0] bytes);
    ext_t b;
    b = ext_t'(bytes);
    return (b > ADDR_MAX_E) ? ADDR_MAX_E : b;
  endfunction

  function automatic ext_t region_down(input ext_t x);
    return x & ~REGION_MASK;
  endfunction

  function automatic ext_t region_up(input ext_t x);
    return (x + REGION_MASK) & ~REGION_MASK;
  endfunction

  localparam ptr_t SCRATCH_RESET = ptr_t'(region_down(arena_size(ARENA_RESET)));

endpackage

>>> hw/rtl/dea_req_if.sv
// Request channel of the arena allocator: valid/ready handshake and request fields.
interface dea_req_if import dea_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SIZE_W-1:0]   req_size;
  logic [ALIGN_W-1:0]  align_log2;
  logic [MARK_W-1:0]   mark;

  modport source (output valid, output func, output req_size, output align_log2,
                  output mark, input ready);
  modport sink   (input valid, input func, input req_size, input align_log2,
                  input mark, output ready);
endinterface

>>> hw/rtl/dea_rsp_if.sv
// Result channel of the arena allocator: valid/ready handshake and result fields.
interface dea_rsp_if import dea_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] offset;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output offset, output status, input ready);
  modport sink   (input valid, input offset, input status, output ready);
endinterface

>>> hw/rtl/dea_calc.sv
// Single-pass evaluation of one allocator request against the current pointers.
module dea_calc import dea_pkg::*; (
  input  logic [FUNC_W-1:0]   func,
  input  logic [SIZE_W-1:0]   req_size,
  input  logic [ALIGN_W-1:0]  align_log2,
  input  logic [MARK_W-1:0]   mark,
  input  ptr_t                perm_end,
  input  ptr_t                scratch_top,
  input  logic [CFG_W-1:0]    arena_bytes,
  output logic [OFFSET_W-1:0] offset,
  output logic [STATUS_W-1:0] status,
  output dea_upd_t            upd
);

  ext_t al_mask;
  ext_t pe_e;
  ext_t st_e;
  ext_t arena_e;
  ext_t region_top;
  ext_t lim;
  ext_t perm_end_new;
  ext_t sz;
  ext_t scr_off;
  ext_t mark_e;
  ext_t res_off;

  always_comb begin
    al_mask      = (ext_t'(1) << align_log2) - ext_t'(1);
    pe_e         = ext_t'(perm_end);
    st_e         = ext_t'(scratch_top);
    arena_e      = arena_size(arena_bytes);
    region_top   = region_down(arena_e);
    // Permanent end rounded up to the alignment: the perm block start and the scratch floor.
    lim          = (pe_e + al_mask) & ~al_mask;
    perm_end_new = lim + ext_t'(req_size);
    sz           = (ext_t'(req_size) + al_mask) & ~al_mask;
    scr_off      = (st_e - sz) & ~al_mask;
    mark_e       = ext_t'(mark);

    res_off      = '0;
    status       = ST_OK;
    upd          = '{perm_we: 1'b0, perm_nxt: perm_end, scr_we: 1'b0, scr_nxt: scratch_top};

    case (func)
      FN_PERM_ALLOC: begin
        if (perm_end_new > arena_e) begin
          status = ST_PERM_OOM;
        end else if (region_up(perm_end_new) > st_e) begin
          status = ST_PERM_CROSS;
        end else begin
          upd.perm_we  = 1'b1;
          upd.perm_nxt = ptr_t'(perm_end_new);
          res_off      = lim;
        end
      end
      FN_SCR_ALLOC: begin
        if ((st_e < lim) || ((st_e - lim) < sz)) begin
          status = ST_SCR_OOM;
        end else if (scr_off < lim) begin
          status = ST_ALIGN_HIT;
        end else begin
          upd.scr_we  = 1'b1;
          upd.scr_nxt = ptr_t'(scr_off);
          res_off     = scr_off;
        end
      end
      FN_REWIND: begin
        if ((mark_e < region_up(pe_e)) || (mark_e > region_top)) begin
          status = ST_BAD_CK;
        end else if (mark_e < st_e) begin
          status = ST_PAST_LIVE;
        end else begin
          upd.scr_we  = 1'b1;
          upd.scr_nxt = ptr_t'(mark_e);
        end
      end
      FN_SCR_RESET: begin
        upd.scr_we  = 1'b1;
        upd.scr_nxt = ptr_t'(region_top);
      end
      FN_READ_MARK: begin
        res_off = st_e;
      end
      FN_CLEAR_ALL: begin
        upd.perm_we  = 1'b1;
        upd.perm_nxt = '0;
        upd.scr_we   = 1'b1;
        upd.scr_nxt  = ptr_t'(region_top);
      end
      default: begin
        // Unused operation codes leave everything as it is.
      end
    endcase

    offset = res_off[OFFSET_W-1:0];
  end

endmodule

>>> hw/rtl/double_ended_arena_allocator.sv
// Top level of the double-ended arena allocator: request/result registers and pointer state.
//
// The block manages a byte arena from two ends: the permanent region grows upward from
// offset zero, the scratch region downward from the arena size rounded down to the region
// granule. Requests arrive on in_req (valid/ready) with an operation code, a size, an
// alignment exponent and a checkpoint mark. Each request yields exactly one result on
// out_rsp (valid/ready), an offset and a status; a failing request moves no pointer.
//
// A request accepted at an edge sits in the input register and is evaluated against the
// pointer registers; when it advances, its result enters the output register and the
// pointers update at the same edge. A request sent back to back thus sees the effects of the
// one before, and one request per cycle is sustained while out_rsp.ready stays high.
//
// While the receiver holds out_rsp.ready low, the result stays in the output register and
// one more request may wait in the input register; in_req.ready then drops. The arena size
// register is written through cfg_we/cfg_wdata; a write moves no pointer, only scratch
// reset and clear-all pick up the new size. Reset (synchronous, rst_n low) empties both
// registers, sets the arena to 3 GiB, the permanent end to zero and the scratch top to the
// arena size rounded down to the region granule.
module double_ended_arena_allocator import dea_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dea_req_if.sink           in_req,
  dea_rsp_if.source         out_rsp,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // Configuration and pointer state.
  logic [CFG_W-1:0]    arena_r;
  ptr_t                perm_end_r;
  ptr_t                scratch_top_r;

  // Input register.
  logic                in_vld_r;
  logic [FUNC_W-1:0]   func_r;
  logic [SIZE_W-1:0]   size_r;
  logic [ALIGN_W-1:0]  align_r;
  logic [MARK_W-1:0]   mark_r;

  // Output register.
  logic                out_vld_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [STATUS_W-1:0] status_r;

  logic [OFFSET_W-1:0] calc_offset;
  logic [STATUS_W-1:0] calc_status;
  dea_upd_t            calc_upd;
  logic                advance;
  logic                in_take;

  // A request moves from the input register to the output register when the output
  // register is empty or its result is being taken in this cycle.
  assign advance       = in_vld_r && (!out_vld_r || out_rsp.ready);
  assign in_req.ready  = !in_vld_r || advance;
  assign in_take       = in_req.valid && in_req.ready;

  assign out_rsp.valid  = out_vld_r;
  assign out_rsp.offset = offset_r;
  assign out_rsp.status = status_r;

  dea_calc u_calc (
    .func        (func_r),
    .req_size    (size_r),
    .align_log2  (align_r),
    .mark        (mark_r),
    .perm_end    (perm_end_r),
    .scratch_top (scratch_top_r),
    .arena_bytes (arena_r),
    .offset      (calc_offset),
    .status      (calc_status),
    .upd         (calc_upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_r       <= ARENA_RESET;
      perm_end_r    <= '0;
      scratch_top_r <= SCRATCH_RESET;
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        arena_r <= cfg_wdata;
      end
      if (advance && calc_upd.perm_we) begin
        perm_end_r <= calc_upd.perm_nxt;
      end
      if (advance && calc_upd.scr_we) begin
        scratch_top_r <= calc_upd.scr_nxt;
      end
      if (in_req.ready) begin
        in_vld_r <= in_req.valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r  <= in_req.func;
      size_r  <= in_req.req_size;
      align_r <= in_req.align_log2;
      mark_r  <= in_req.mark;
    end
    if (advance) begin
      offset_r <= calc_offset;
      status_r <= calc_status;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended arena allocator: directed and random requests.
module tb_top import dea_pkg::*; ;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 11;
  // The slowest correct run is roughly 500 requests, each behind the longest sender gap, the
  // longest receiver stall and its way through the block; the limit is many times that.
  localparam int CYCLE_LIMIT     = 200000;
  // A result passes the input and output registers, so a short tail covers any stray result.
  localparam int DRAIN_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int N_PHASES        = 9;
  localparam int MAX_SAVED_MARKS = 16;
  localparam int MAX_PRINTED     = 50;

  // Operation codes that the block accepts but leaves without effect.
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [SIZE_W-1:0]  req_size;
    logic [ALIGN_W-1:0] align_log2;
    logic [MARK_W-1:0]  mark;
  } arena_req_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [STATUS_W-1:0] status;
  } arena_res_t;

  // Keeps a private copy of the arena size and both pointers, works out the result of
  // every accepted request in acceptance order, and compares the block's results with it.
  class arena_checker;
    bit [CFG_W-1:0] arena_bytes;
    bit [63:0]      perm_end;
    bit [63:0]      scratch_top;
    arena_res_t     due_results[$];
    int             errors;

    function new();
      arena_bytes = ARENA_RESET;
      perm_end    = 0;
      scratch_top = granule_down(arena_limit());
      errors      = 0;
    endfunction

    // The size register saturates at the largest address.
    function bit [63:0] arena_limit();
      bit [63:0] top;
      top = (64'd1 << ADDR_BITS) - 64'd1;
      return ({32'b0, arena_bytes} > top) ? top : {32'b0, arena_bytes};
    endfunction

    function bit [63:0] granule_down(bit [63:0] x);
      return x & ~((64'd1 << REGION_LOG2) - 64'd1);
    endfunction

    function bit [63:0] granule_up(bit [63:0] x);
      return (x + (64'd1 << REGION_LOG2) - 64'd1) & ~((64'd1 << REGION_LOG2) - 64'd1);
    endfunction

    function void note_request(arena_req_t r);
      bit [63:0]  al, off, blk_end, sz, lim, arena, mark64, size64;
      arena_res_t res;
      arena      = arena_limit();
      al         = 64'd1 << r.align_log2;
      size64     = {32'b0, r.req_size};
      mark64     = {32'b0, r.mark};
      res.offset = '0;
      res.status = ST_OK;
      case (r.func)
        FN_PERM_ALLOC: begin
          off     = (perm_end + al - 64'd1) & ~(al - 64'd1);
          blk_end = off + size64;
          if (blk_end > arena)
            res.status = ST_PERM_OOM;
          else if (granule_up(blk_end) > scratch_top)
            res.status = ST_PERM_CROSS;
          else begin
            perm_end   = blk_end;
            res.offset = off[OFFSET_W-1:0];
          end
        end
        FN_SCR_ALLOC: begin
          sz  = (size64 + al - 64'd1) & ~(al - 64'd1);
          lim = (perm_end + al - 64'd1) & ~(al - 64'd1);
          if (scratch_top < lim || scratch_top - lim < sz)
            res.status = ST_SCR_OOM;
          else begin
            off = (scratch_top - sz) & ~(al - 64'd1);
            if (off < lim)
              res.status = ST_ALIGN_HIT;
            else begin
              scratch_top = off;
              res.offset  = off[OFFSET_W-1:0];
            end
          end
        end
        FN_REWIND: begin
          if (mark64 < granule_up(perm_end) || mark64 > granule_down(arena))
            res.status = ST_BAD_CK;
          else if (mark64 < scratch_top)
            res.status = ST_PAST_LIVE;
          else
            scratch_top = mark64;
        end
        FN_SCR_RESET: scratch_top = granule_down(arena);
        FN_READ_MARK: res.offset = scratch_top[OFFSET_W-1:0];
        FN_CLEAR_ALL: begin
          perm_end    = 0;
          scratch_top = granule_down(arena);
        end
        default: ;
      endcase
      due_results.insert(due_results.size(), res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task check_result(logic [OFFSET_W-1:0] offset, logic [STATUS_W-1:0] status);
      arena_res_t want;
      if (due_results.size() == 0) begin
        report("result with nothing outstanding", offset, 32'd0);
        return;
      end
      want = due_results.pop_front();
      if (offset !== want.offset)
        report("offset", offset, want.offset);
      if (status !== want.status)
        report("status", 32'(status), 32'(want.status));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  dea_req_if req_ch ();
  dea_rsp_if rsp_ch ();

  arena_checker book;
  bit           no_idle;
  int           stall_left;
  // Scratch tops read back earlier; they serve as rewind marks, some of them stale.
  bit [63:0]    saved_marks[$];

  double_ended_arena_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // The receiver stalls in random bursts unless idling is switched off.
  always @(negedge clk) begin
    if (no_idle) begin
      stall_left = 0;
      rsp_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 10);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Every accepted result is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      book.check_result(rsp_ch.offset, rsp_ch.status);
  end

  // A hung handshake ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic arena_req_t request_of(logic [FUNC_W-1:0] func, logic [SIZE_W-1:0] size,
                                            logic [ALIGN_W-1:0] align, logic [MARK_W-1:0] mark);
    arena_req_t r;
    r.func       = func;
    r.req_size   = size;
    r.align_log2 = align;
    r.mark       = mark;
    return r;
  endfunction

  // Sizes lean toward small blocks and toward the free room between the two regions, so
  // that exact fits and near misses come up often; a few are fully random.
  function automatic logic [SIZE_W-1:0] pick_size();
    bit [63:0] room;
    room = (book.scratch_top > book.perm_end) ? book.scratch_top - book.perm_end : 64'd0;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 64);
      3, 4, 5: return $urandom_range(0, 4096);
      6, 7:    return $urandom_range(0, room[31:0]);
      8:       return room[31:0] + $urandom_range(0, 2) - 1;
      default: return $urandom();
    endcase
  endfunction

  // Rewind marks sit mostly on the edges that decide the outcome: saved checkpoints, the
  // live scratch top, the first legal granule above the permanent region and the arena top.
  function automatic logic [MARK_W-1:0] pick_mark();
    bit [63:0] base;
    case ($urandom_range(0, 5))
      0: begin
        if (saved_marks.size() != 0)
          base = saved_marks[$urandom_range(0, saved_marks.size() - 1)];
        else
          base = book.scratch_top;
      end
      1:       base = book.scratch_top + 64'd256 * $urandom_range(0, 16);
      2:       base = book.granule_up(book.perm_end) - $urandom_range(0, 1);
      3:       base = book.granule_down(book.arena_limit()) + $urandom_range(0, 1);
      4:       base = book.scratch_top - $urandom_range(1, 300);
      default: base = $urandom();
    endcase
    return base[MARK_W-1:0];
  endfunction

  // Mostly well-formed traffic built from the current pointers, plus some requests with
  // fully random fields and some with the spare operation codes.
  function automatic arena_req_t next_request();
    arena_req_t  r;
    int unsigned pick;
    r.req_size   = $urandom();
    r.align_log2 = ($urandom_range(0, 4) == 0) ? ALIGN_W'($urandom_range(0, 15))
                                               : ALIGN_W'($urandom_range(0, 8));
    r.mark       = $urandom();
    pick         = $urandom_range(0, 99);
    if (pick < 30) begin
      r.func     = FN_PERM_ALLOC;
      r.req_size = pick_size();
    end else if (pick < 58) begin
      r.func     = FN_SCR_ALLOC;
      r.req_size = pick_size();
    end else if (pick < 68) begin
      r.func = FN_READ_MARK;
      saved_marks.insert(saved_marks.size(), book.scratch_top);
      if (saved_marks.size() > MAX_SAVED_MARKS)
        void'(saved_marks.pop_front());
    end else if (pick < 82) begin
      r.func = FN_REWIND;
      r.mark = pick_mark();
    end else if (pick < 87) begin
      r.func = FN_SCR_RESET;
    end else if (pick < 91) begin
      r.func = FN_CLEAR_ALL;
    end else if (pick < 97) begin
      r.func = FUNC_W'($urandom_range(0, 7));
    end else begin
      r.func = ($urandom_range(0, 1) == 0) ? FN_SPARE_6 : FN_SPARE_7;
    end
    return r;
  endfunction

  // Presents one request, possibly after a random gap, and waits for its acceptance.
  // The prediction is made at the accepting edge, so the next request is built from the
  // pointers as they will be when it reaches the block.
  task automatic send_request(input arena_req_t r);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= r.func;
    req_ch.req_size   <= r.req_size;
    req_ch.align_log2 <= r.align_log2;
    req_ch.mark       <= r.mark;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    book.note_request(r);
  endtask

  // Stops requesting and waits until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (book.due_results.size() != 0) @(posedge clk);
  endtask

  // The size register is written only with the block idle; the pointers stay where they
  // are until a scratch reset or a clear-all picks up the new size.
  task automatic set_arena(input logic [CFG_W-1:0] bytes);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    book.arena_bytes = bytes;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] arena_settings [N_PHASES];
    book       = new();
    no_idle    = 1'b0;
    stall_left = 0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    req_ch.valid      = 1'b0;
    req_ch.func       = FN_PERM_ALLOC;
    req_ch.req_size   = '0;
    req_ch.align_log2 = '0;
    req_ch.mark       = '0;
    rsp_ch.ready      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset arena size of 3 GiB. It walks the permanent region up,
    // pulls the scratch top down, and hits each error status that the pointers allow.
    send_request(request_of(FN_READ_MARK, 32'd0, 4'd0, 32'd0));
    send_request(request_of(FN_PERM_ALLOC, 32'd0, 4'd0, 32'd0));
    send_request(request_of(FN_PERM_ALLOC, 32'd100, 4'd0, 32'd0));
    send_request(request_of(FN_PERM_ALLOC, 32'd1, 4'd12, 32'd0));
    // Largest size at the largest alignment code: out of memory.
    send_request(request_of(FN_PERM_ALLOC, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF));
    send_request(request_of(FN_SCR_ALLOC, 32'h100, 4'd8, 32'd0));
    send_request(request_of(FN_READ_MARK, 32'd0, 4'd0, 32'd0));
    // Ends one byte into the granule that holds the scratch top, so it crosses it.
    send_request(request_of(FN_PERM_ALLOC, 32'hBFFF_EF00, 4'd0, 32'd0));
    send_request(request_of(FN_SCR_ALLOC, 32'hFFFF_FFFF, 4'd0, 32'd0));
    send_request(request_of(FN_SCR_ALLOC, 32'd0, 4'd15, 32'd0));
    send_request(request_of(FN_REWIND, 32'd0, 4'd0, 32'hBFFF_FF00));
    send_request(request_of(FN_REWIND, 32'd0, 4'd0, 32'h0000_0100));
    send_request(request_of(FN_REWIND, 32'd0, 4'd0, 32'hC000_0001));
    send_request(request_of(FN_REWIND, 32'd0, 4'd0, 32'hBFFF_0000));
    send_request(request_of(FN_REWIND, 32'd0, 4'd0, 32'hC000_0000));
    send_request(request_of(FN_SPARE_6, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF));
    send_request(request_of(FN_SPARE_7, 32'd0, 4'd0, 32'd0));
    send_request(request_of(FN_SCR_RESET, 32'd0, 4'd0, 32'd0));
    send_request(request_of(FN_CLEAR_ALL, 32'd0, 4'd0, 32'd0));

    // An empty arena: the scratch top sits at zero and is still a valid top.
    set_arena(32'd0);
    send_request(request_of(FN_CLEAR_ALL, 32'd0, 4'd0, 32'd0));
    send_request(request_of(FN_PERM_ALLOC, 32'd0, 4'd0, 32'd0));
    send_request(request_of(FN_SCR_ALLOC, 32'd0, 4'd0, 32'd0));
    send_request(request_of(FN_REWIND, 32'd0, 4'd0, 32'd0));
    send_request(request_of(FN_PERM_ALLOC, 32'd1, 4'd0, 32'd0));

    // Random phases, each at its own arena size; the last one runs without idling.
    arena_settings[0] = 32'hFFFF_FFFF;
    arena_settings[1] = 32'd255;
    arena_settings[2] = 32'd256;
    arena_settings[3] = 32'd4096;
    arena_settings[4] = $urandom_range(300, 32'h0010_0000);
    arena_settings[5] = 32'h0001_0000;
    arena_settings[6] = $urandom();
    arena_settings[7] = 32'h1234_5678;
    arena_settings[8] = ARENA_RESET;
    for (int p = 0; p < N_PHASES; p++) begin
      set_arena(arena_settings[p]);
      no_idle = (p == N_PHASES - 1) || ($urandom_range(0, 4) == 0);
      // Usually start from an empty arena at the new size; otherwise keep the old pointers.
      if ($urandom_range(0, 3) != 0)
        send_request(request_of(FN_CLEAR_ALL, $urandom(), ALIGN_W'($urandom()), $urandom()));
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_request(next_request());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/dea_pkg.sv
hw/rtl/dea_req_if.sv
hw/rtl/dea_rsp_if.sv
hw/rtl/dea_calc.sv
hw/rtl/double_ended_arena_allocator.sv
tb/sv/tb_top.sv
